### sv/ccs_pkg.sv
// Shared constants, types and helper functions of the coulomb counter.
package ccs_pkg;

	localparam int ACC_WIDTH  = 48;
	localparam int OUT_W      = 48;
	localparam int CUR_W      = 32;
	localparam int ANCHOR_W   = 16;
	localparam int SOC_W      = 14;
	localparam int CAP_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int UAS_PER_MAH = 3600 * 1000;
	localparam int DEN_W       = CAP_W + $clog2(UAS_PER_MAH);
	localparam int NUM_W       = ACC_WIDTH + SOC_W;
	localparam int CNT_W       = $clog2(NUM_W + 1);
	localparam int MAX_W       = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

	localparam logic [SOC_W-1:0] SOC_FULL    = SOC_W'(10000);
	localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(2000);
	localparam logic [SOC_W-1:0] ANCHOR_INIT = SOC_W'(10000);

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_SOC = CFG_IDX_W'(1);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_ANCHOR = 1'b1;

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic store;
	} cmd_t;

	// Saturates the accumulator to the signed range of the charge output.
	function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_WIDTH-1:0] a);
		logic signed [MAX_W-1:0] x;
		logic signed [MAX_W-1:0] hi;
		logic signed [MAX_W-1:0] lo;
		logic signed [MAX_W-1:0] r;
		x  = MAX_W'(a);
		hi = MAX_W'({1'b0, {(OUT_W-1){1'b1}}});
		lo = -hi - MAX_W'(1);
		if (x > hi) begin
			r = hi;
		end else if (x < lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage

### sv/ccs_in_if.sv
// Input channel: one current sample or re-anchor word per handshake.
interface ccs_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic signed [ccs_pkg::CUR_W-1:0]      current_ua;
	logic signed [ccs_pkg::ANCHOR_W-1:0]   soc_anchor;

	modport source (output valid, op, current_ua, soc_anchor, input ready);
	modport sink (input valid, op, current_ua, soc_anchor, output ready);
endinterface

### sv/ccs_out_if.sv
// Output channel: one state-of-charge and charge word per handshake.
interface ccs_out_if;
	logic                               valid;
	logic                               ready;
	logic [ccs_pkg::SOC_W-1:0]          soc_level;
	logic signed [ccs_pkg::OUT_W-1:0]   charge_out_uas;

	modport source (output valid, soc_level, charge_out_uas, input ready);
	modport sink (input valid, soc_level, charge_out_uas, output ready);
endinterface

### sv/ccs_ctrl.sv
// Controller state machine: handshakes, multiply, divide sequencing and output valid.
module ccs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ccs_pkg::cmd_t cmd
);

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] S_IDLE = 2'd0;
	localparam logic [ST_W-1:0] S_MUL  = 2'd1;
	localparam logic [ST_W-1:0] S_DIV  = 2'd2;
	localparam logic [ST_W-1:0] S_FIN  = 2'd3;

	logic [ST_W-1:0]           state_q;
	logic [ccs_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load  = in_valid && (state_q == S_IDLE);
		cmd.mul   = (state_q == S_MUL);
		cmd.div   = (state_q == S_DIV);
		cmd.store = (state_q == S_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= ccs_pkg::CNT_W'(ccs_pkg::NUM_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.store) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_MUL)
		else $error("accepted word did not start the multiply step");
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (!out_valid_q || out_ready))
		else $error("result stored over a word not yet taken");
	a_store_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> out_valid_q)
		else $error("stored result not presented");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> state_q == S_FIN)
		else $error("divider did not finish after its last step");

endmodule

### sv/ccs_dp.sv
// Datapath: configuration, saturating accumulator, anchor, restoring divider, result register.
module ccs_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ccs_pkg::cmd_t                        cmd,
	input  logic                                 op,
	input  logic signed [ccs_pkg::CUR_W-1:0]     current_ua,
	input  logic signed [ccs_pkg::ANCHOR_W-1:0]  soc_anchor,
	input  logic                                 cfg_we,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [ccs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic [ccs_pkg::SOC_W-1:0]            soc_level,
	output logic signed [ccs_pkg::OUT_W-1:0]     charge_out_uas
);

	logic [ccs_pkg::CAP_W-1:0]             cap_q;
	logic signed [ccs_pkg::ACC_WIDTH-1:0]  acc_q;
	logic [ccs_pkg::SOC_W-1:0]             anchor_q;
	logic                                  neg_q;
	logic [ccs_pkg::NUM_W-1:0]             num_q;
	logic [ccs_pkg::DEN_W-1:0]             den_q;
	logic [ccs_pkg::DEN_W-1:0]             rem_q;
	logic [ccs_pkg::SOC_W-1:0]             soc_q;
	logic [ccs_pkg::OUT_W-1:0]             charge_q;

	logic signed [ccs_pkg::ACC_WIDTH:0]    sum;
	logic signed [ccs_pkg::ACC_WIDTH-1:0]  acc_next;
	logic [ccs_pkg::SOC_W-1:0]             anchor_next;
	logic [ccs_pkg::ACC_WIDTH-1:0]         mag;
	logic [ccs_pkg::CAP_W-1:0]             cap_eff;
	logic [ccs_pkg::DEN_W:0]               trial;
	logic [ccs_pkg::DEN_W:0]               diff;
	logic                                  ge;
	logic [ccs_pkg::SOC_W:0]               up_sum;
	logic [ccs_pkg::SOC_W-1:0]             soc_next;

	always_comb begin
		sum = (ccs_pkg::ACC_WIDTH+1)'(acc_q) + (ccs_pkg::ACC_WIDTH+1)'(current_ua);
		if (sum[ccs_pkg::ACC_WIDTH] != sum[ccs_pkg::ACC_WIDTH-1]) begin
			acc_next = sum[ccs_pkg::ACC_WIDTH] ?
				{1'b1, {(ccs_pkg::ACC_WIDTH-1){1'b0}}} :
				{1'b0, {(ccs_pkg::ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_next = sum[ccs_pkg::ACC_WIDTH-1:0];
		end
		if (soc_anchor < 0) begin
			anchor_next = '0;
		end else if (soc_anchor > ccs_pkg::ANCHOR_W'(ccs_pkg::SOC_FULL)) begin
			anchor_next = ccs_pkg::SOC_FULL;
		end else begin
			anchor_next = soc_anchor[ccs_pkg::SOC_W-1:0];
		end
	end

	assign mag     = acc_q[ccs_pkg::ACC_WIDTH-1] ? -acc_q : acc_q;
	assign cap_eff = (cap_q == '0) ? ccs_pkg::CAP_W'(1) : cap_q;

	assign trial = {rem_q, num_q[ccs_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_comb begin
		up_sum = {1'b0, anchor_q} + (ccs_pkg::SOC_W+1)'(num_q[ccs_pkg::SOC_W-1:0]);
		if (neg_q) begin
			if (num_q >= ccs_pkg::NUM_W'(ccs_pkg::SOC_FULL)) begin
				soc_next = ccs_pkg::SOC_FULL;
			end else if (up_sum > (ccs_pkg::SOC_W+1)'(ccs_pkg::SOC_FULL)) begin
				soc_next = ccs_pkg::SOC_FULL;
			end else begin
				soc_next = up_sum[ccs_pkg::SOC_W-1:0];
			end
		end else begin
			if (num_q >= ccs_pkg::NUM_W'(anchor_q)) begin
				soc_next = '0;
			end else begin
				soc_next = anchor_q - num_q[ccs_pkg::SOC_W-1:0];
			end
		end
	end

	// Writes to the initial SOC register index are ignored, so they leave no state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= ccs_pkg::CAP_RESET;
			acc_q    <= '0;
			anchor_q <= ccs_pkg::ANCHOR_INIT;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					ccs_pkg::CFG_CAPACITY: cap_q <= cfg_wdata[ccs_pkg::CAP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (op == ccs_pkg::OP_ANCHOR) begin
					anchor_q <= anchor_next;
					acc_q    <= '0;
				end else begin
					acc_q <= acc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			neg_q <= acc_q[ccs_pkg::ACC_WIDTH-1];
			num_q <= ccs_pkg::NUM_W'(mag) * ccs_pkg::NUM_W'(ccs_pkg::SOC_FULL);
			den_q <= ccs_pkg::DEN_W'(cap_eff) * ccs_pkg::DEN_W'(ccs_pkg::UAS_PER_MAH);
			rem_q <= '0;
		end else if (cmd.div) begin
			rem_q <= ge ? diff[ccs_pkg::DEN_W-1:0] : trial[ccs_pkg::DEN_W-1:0];
			num_q <= {num_q[ccs_pkg::NUM_W-2:0], ge};
		end
		if (cmd.store) begin
			soc_q    <= soc_next;
			charge_q <= ccs_pkg::sat_out(acc_q);
		end
	end

	assign soc_level      = soc_q;
	assign charge_out_uas = charge_q;

endmodule

### sv/coulomb_counter_soc_top.sv
// Top level of the coulomb-counting state-of-charge estimator.
//
//   channel  | dir | words
//   sample   | in  | op, current_ua, soc_anchor
//   result   | out | soc_level, charge_out_uas
//   cfg      | in  | cfg_we, cfg_idx, cfg_wdata (capacity, initial SOC)
//
// Each word goes from acceptance to a valid result through one multiply, NUM_W restoring
// divide steps and one store, with the accumulate done at the accepting edge; the next
// word is taken once the controller has returned to idle after the store.
// Reset is asynchronous; the anchor loads 10000 and the accumulator clears, no sweep.
// A new word is accepted while the previous result waits in the output register; a
// finished result holds in the final step until that register is free.
module coulomb_counter_soc_top (
	input  logic                                clk,
	input  logic                                arst_n,
	ccs_in_if.sink                              sample,
	ccs_out_if.source                           result,
	input  logic                                cfg_we,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [ccs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	ccs_pkg::cmd_t cmd;

	ccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	ccs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op             (sample.op),
		.current_ua     (sample.current_ua),
		.soc_anchor     (sample.soc_anchor),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.soc_level      (result.soc_level),
		.charge_out_uas (result.charge_out_uas)
	);

endmodule
